// ===== rtl/isf_pkg.sv =====
// Shared types and constants for the scaled image size and filter block.
`timescale 1ns / 1ps
package isf_pkg;

    localparam int DEF_FRAC_BITS = 16;
    localparam int COEF_W        = 32;
    localparam int SIDE_PX_W     = 15;
    localparam int SIZE_W        = 16;
    localparam int RAD_W         = 64;
    localparam int ROOT_W        = 32;
    localparam int HYP_W         = 33;
    localparam int LANES         = 2;

    // Fields that ride along with the root computation.
    typedef struct packed {
        logic signed [COEF_W-1:0]    x0;
        logic signed [COEF_W-1:0]    y0;
        logic        [SIDE_PX_W-1:0] sw;
        logic        [SIDE_PX_W-1:0] sh;
        logic                        interp;
    } t_side;

endpackage

// ===== rtl/isf_sqrt_pipe.sv =====
// Two-lane pipelined floor square root, one result bit per stage.
`timescale 1ns / 1ps
module isf_sqrt_pipe (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_vld,
    input  logic [isf_pkg::RAD_W-1:0]             i_rad   [isf_pkg::LANES],
    input  logic                                  i_shift [isf_pkg::LANES],
    input  isf_pkg::t_side                        i_side,
    output logic                                  o_vld,
    output logic [isf_pkg::HYP_W-1:0]             o_root  [isf_pkg::LANES],
    output isf_pkg::t_side                        o_side
);
    localparam int NST = isf_pkg::ROOT_W;

    logic [isf_pkg::RAD_W-1:0]  r_n    [1:NST][isf_pkg::LANES];
    logic [isf_pkg::ROOT_W+1:0] r_rem  [1:NST][isf_pkg::LANES];
    logic [isf_pkg::ROOT_W-1:0] r_root [1:NST][isf_pkg::LANES];
    logic                       r_sh   [1:NST][isf_pkg::LANES];
    isf_pkg::t_side             r_side [1:NST];
    logic                       r_vld  [1:NST];

    for (genvar k = 0; k < NST; k++) begin : g_stage
        logic [isf_pkg::RAD_W-1:0]  w_n    [isf_pkg::LANES];
        logic [isf_pkg::ROOT_W+1:0] w_rem  [isf_pkg::LANES];
        logic [isf_pkg::ROOT_W-1:0] w_root [isf_pkg::LANES];
        logic                       w_sh   [isf_pkg::LANES];
        isf_pkg::t_side             w_side;
        logic                       w_vld;
        logic [isf_pkg::ROOT_W+3:0] n_cur   [isf_pkg::LANES];
        logic [isf_pkg::ROOT_W+3:0] n_trial [isf_pkg::LANES];
        logic [isf_pkg::ROOT_W+3:0] n_diff  [isf_pkg::LANES];

        // Feed the first stage from the ports, the others from the stage before.
        if (k == 0) begin : g_head
            always_comb begin
                for (int l = 0; l < isf_pkg::LANES; l++) begin
                    w_n[l]    = i_rad[l];
                    w_rem[l]  = '0;
                    w_root[l] = '0;
                    w_sh[l]   = i_shift[l];
                end
                w_side = i_side;
                w_vld  = i_vld;
            end
        end else begin : g_tail
            always_comb begin
                for (int l = 0; l < isf_pkg::LANES; l++) begin
                    w_n[l]    = r_n[k][l];
                    w_rem[l]  = r_rem[k][l];
                    w_root[l] = r_root[k][l];
                    w_sh[l]   = r_sh[k][l];
                end
                w_side = r_side[k];
                w_vld  = r_vld[k];
            end
        end

        always_comb begin
            for (int l = 0; l < isf_pkg::LANES; l++) begin
                n_cur[l]   = {w_rem[l], w_n[l][isf_pkg::RAD_W-1 -: 2]};
                n_trial[l] = {2'b00, w_root[l], 2'b01};
                n_diff[l]  = n_cur[l] - n_trial[l];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k+1] <= w_side;
                for (int l = 0; l < isf_pkg::LANES; l++) begin
                    r_n[k+1][l] <= {w_n[l][isf_pkg::RAD_W-3:0], 2'b00};
                    r_sh[k+1][l] <= w_sh[l];
                    if (n_cur[l] >= n_trial[l]) begin
                        r_rem[k+1][l]  <= n_diff[l][isf_pkg::ROOT_W+1:0];
                        r_root[k+1][l] <= {w_root[l][isf_pkg::ROOT_W-2:0], 1'b1};
                    end else begin
                        r_rem[k+1][l]  <= n_cur[l][isf_pkg::ROOT_W+1:0];
                        r_root[k+1][l] <= {w_root[l][isf_pkg::ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Undo the pre-shift of large operands.
    always_comb begin
        for (int l = 0; l < isf_pkg::LANES; l++) begin
            o_root[l] = r_sh[NST][l] ? {r_root[NST][l], 1'b0} : {1'b0, r_root[NST][l]};
        end
    end
    assign o_vld  = r_vld[NST];
    assign o_side = r_side[NST];

endmodule

// ===== rtl/image_scaled_size_and_filter.sv =====
// Top level: singular values of a 2x2 transform, scaled image size and filter choice.
`timescale 1ns / 1ps
// Pipeline: 4 front stages, 32 root stages and 3 back stages; the bit-per-stage
//   square root sets the depth.
// Throughput: one item per cycle; the whole pipeline advances together and
//   holds when the result register is full and not taken.
// Reset: synchronous, active low; clears every stage valid, no payload reset.
module image_scaled_size_and_filter #(
    parameter int FRAC_BITS = isf_pkg::DEF_FRAC_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // low to high: matrix_xx[31:0], matrix_yx, matrix_xy, matrix_yy, offset_x, offset_y,
    // source_width[14:0], source_height[14:0], interpolate_req, one zero pad bit
    input  logic [223:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // low to high: device width[15:0], device height[15:0], filter_sel, seven zero bits
    output logic [39:0]  o_m_tdata
);
    localparam int CW = isf_pkg::COEF_W;
    localparam int PW = CW + 1;        // sum or difference of two coefficients
    localparam int VW = 36;            // coordinate math width
    localparam logic signed [VW-1:0] MARGIN = VW'(((64'sd1 <<< FRAC_BITS) + 50) / 100);
    localparam logic signed [VW-1:0] HALF   = VW'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [VW-1:0] ONE_M1 = VW'((64'sd1 <<< FRAC_BITS) - 1);
    localparam logic [VW-1:0]        SAT    = VW'(65535);

    // Global advance: move everything while the result slot is free or being taken.
    logic w_en;
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = w_en;

    // ---------------- input unpack ----------------
    logic signed [CW-1:0] w_xx, w_yx, w_xy, w_yy;
    isf_pkg::t_side       w_side;
    always_comb begin
        w_xx          = i_s_tdata[31:0];
        w_yx          = i_s_tdata[63:32];
        w_xy          = i_s_tdata[95:64];
        w_yy          = i_s_tdata[127:96];
        w_side.x0     = i_s_tdata[159:128];
        w_side.y0     = i_s_tdata[191:160];
        w_side.sw     = i_s_tdata[206:192];
        w_side.sh     = i_s_tdata[221:207];
        w_side.interp = i_s_tdata[222];
    end

    // ---------------- stage 1: sums and differences ----------------
    // lane 0 gives E: (xx+yy, yx-xy); lane 1 gives F: (xx-yy, yx+xy)
    logic signed [PW-1:0] r1_p [isf_pkg::LANES];
    logic signed [PW-1:0] r1_q [isf_pkg::LANES];
    isf_pkg::t_side       r1_side;
    logic                 r1_vld;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_p[0] <= PW'(w_xx) + PW'(w_yy);
            r1_q[0] <= PW'(w_yx) - PW'(w_xy);
            r1_p[1] <= PW'(w_xx) - PW'(w_yy);
            r1_q[1] <= PW'(w_yx) + PW'(w_xy);
            r1_side <= w_side;
        end
    end

    // ---------------- stage 2: magnitudes, pre-shift of large operands ----------------
    logic [CW-1:0]  r2_u  [isf_pkg::LANES];
    logic [CW-1:0]  r2_v  [isf_pkg::LANES];
    logic           r2_sh [isf_pkg::LANES];
    isf_pkg::t_side r2_side;
    logic           r2_vld;
    logic [PW-1:0]  n_mu  [isf_pkg::LANES];
    logic [PW-1:0]  n_mv  [isf_pkg::LANES];
    logic           n_big [isf_pkg::LANES];

    always_comb begin
        for (int l = 0; l < isf_pkg::LANES; l++) begin
            n_mu[l]  = r1_p[l][PW-1] ? PW'(-r1_p[l]) : PW'(r1_p[l]);
            n_mv[l]  = r1_q[l][PW-1] ? PW'(-r1_q[l]) : PW'(r1_q[l]);
            n_big[l] = |n_mu[l][PW-1:PW-2] || |n_mv[l][PW-1:PW-2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < isf_pkg::LANES; l++) begin
                r2_u[l]  <= n_big[l] ? n_mu[l][PW-1:1] : n_mu[l][CW-1:0];
                r2_v[l]  <= n_big[l] ? n_mv[l][PW-1:1] : n_mv[l][CW-1:0];
                r2_sh[l] <= n_big[l];
            end
            r2_side <= r1_side;
        end
    end

    // ---------------- stage 3: squares ----------------
    logic [2*CW-1:0] r3_uu [isf_pkg::LANES];
    logic [2*CW-1:0] r3_vv [isf_pkg::LANES];
    logic            r3_sh [isf_pkg::LANES];
    isf_pkg::t_side  r3_side;
    logic            r3_vld;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < isf_pkg::LANES; l++) begin
                r3_uu[l] <= r2_u[l] * r2_u[l];
                r3_vv[l] <= r2_v[l] * r2_v[l];
                r3_sh[l] <= r2_sh[l];
            end
            r3_side <= r2_side;
        end
    end

    // ---------------- stage 4: sum of squares (at most 2^63) ----------------
    logic [isf_pkg::RAD_W-1:0] r4_rad [isf_pkg::LANES];
    logic                      r4_sh  [isf_pkg::LANES];
    isf_pkg::t_side            r4_side;
    logic                      r4_vld;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int l = 0; l < isf_pkg::LANES; l++) begin
                r4_rad[l] <= r3_uu[l] + r3_vv[l];
                r4_sh[l]  <= r3_sh[l];
            end
            r4_side <= r3_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_s_tvalid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    // ---------------- root stages ----------------
    logic [isf_pkg::HYP_W-1:0] w_root [isf_pkg::LANES];
    isf_pkg::t_side            w_rside;
    logic                      w_rvld;

    isf_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r4_vld),
        .i_rad   (r4_rad),
        .i_shift (r4_sh),
        .i_side  (r4_side),
        .o_vld   (w_rvld),
        .o_root  (w_root),
        .o_side  (w_rside)
    );

    // ---------------- stage A: major/minor, give the larger scale to the longer side ----------------
    logic [isf_pkg::HYP_W:0]   n_sum;
    logic [isf_pkg::HYP_W-1:0] n_dif;
    logic [isf_pkg::HYP_W-1:0] n_major, n_minor;
    logic [isf_pkg::HYP_W-1:0] ra_xs, ra_ys;
    isf_pkg::t_side            ra_side;
    logic                      ra_vld;

    always_comb begin
        n_sum   = {1'b0, w_root[0]} + {1'b0, w_root[1]};
        n_dif   = (w_root[0] >= w_root[1]) ? (w_root[0] - w_root[1]) : (w_root[1] - w_root[0]);
        n_major = n_sum[isf_pkg::HYP_W:1];
        n_minor = {1'b0, n_dif[isf_pkg::HYP_W-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_rside.sw > w_rside.sh) begin
                ra_xs <= n_major;
                ra_ys <= n_minor;
            end else begin
                ra_xs <= n_minor;
                ra_ys <= n_major;
            end
            ra_side <= w_rside;
        end
    end

    // ---------------- stage B: device-space extents ----------------
    logic signed [VW-1:0] n_x0, n_y0, n_xs, n_ys;
    logic signed [VW-1:0] n_tx, n_tx2, n_ty, n_ty2, n_dw, n_dh;
    logic [VW-1:0]        n_aw, n_ah;
    logic [isf_pkg::SIZE_W-1:0] rb_w, rb_h;
    logic [isf_pkg::SIDE_PX_W-1:0] rb_sw, rb_sh;
    logic                 rb_interp;
    logic                 rb_vld;

    always_comb begin
        n_x0  = VW'(ra_side.x0);
        n_y0  = VW'(ra_side.y0);
        n_xs  = VW'({1'b0, ra_xs});
        n_ys  = VW'({1'b0, ra_ys});
        n_tx  = (n_x0 - MARGIN + HALF) >>> FRAC_BITS;
        n_tx2 = ((n_x0 + n_xs + MARGIN + HALF) >>> FRAC_BITS) - VW'(1);
        n_ty  = (n_y0 + MARGIN) >>> FRAC_BITS;
        n_ty2 = (n_y0 + n_ys - MARGIN + ONE_M1) >>> FRAC_BITS;     // ceiling
        n_dw  = n_tx2 - n_tx;
        n_dh  = n_ty2 - n_ty;
        n_aw  = (n_dw[VW-1] ? VW'(-n_dw) : VW'(n_dw)) + VW'(1);
        n_ah  = n_dh[VW-1] ? VW'(-n_dh) : VW'(n_dh);
        if (n_ah == '0) begin
            n_ah = VW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rb_w      <= (n_aw > SAT) ? '1 : n_aw[isf_pkg::SIZE_W-1:0];
            rb_h      <= (n_ah > SAT) ? '1 : n_ah[isf_pkg::SIZE_W-1:0];
            rb_sw     <= ra_side.sw;
            rb_sh     <= ra_side.sh;
            rb_interp <= ra_side.interp;
        end
    end

    // ---------------- stage C: filter choice, result register ----------------
    // floor(w / sw) >= 4 is the same as w >= 4 * sw
    logic [isf_pkg::SIDE_PX_W+1:0] n_sw4, n_sh4;
    logic                          n_filt;
    logic [isf_pkg::SIZE_W-1:0]    rc_w, rc_h;
    logic                          rc_filt;
    logic                          rc_vld;

    always_comb begin
        n_sw4 = {rb_sw, 2'b00};
        n_sh4 = {rb_sh, 2'b00};
        if (rb_interp) begin
            n_filt = 1'b1;
        end else if (rb_sw == '0 || rb_sh == '0) begin
            n_filt = 1'b0;
        end else if ((isf_pkg::SIDE_PX_W+2)'(rb_w) >= n_sw4
                  || (isf_pkg::SIDE_PX_W+2)'(rb_h) >= n_sh4) begin
            n_filt = 1'b0;
        end else begin
            n_filt = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rc_w    <= rb_w;
            rc_h    <= rb_h;
            rc_filt <= n_filt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_vld <= 1'b0;
            rb_vld <= 1'b0;
            rc_vld <= 1'b0;
        end else if (w_en) begin
            ra_vld <= w_rvld;
            rb_vld <= ra_vld;
            rc_vld <= rb_vld;
        end
    end

    assign o_m_tvalid = rc_vld;
    assign o_m_tdata  = {7'b0, rc_filt, rc_h, rc_w};

endmodule

// ===== rtl/isf_checker.sv =====
// Port-level checks for the scaled image size and filter block.
`timescale 1ns / 1ps
module isf_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [39:0]  o_m_tdata
);
    a_width_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[15:0] != 16'd0)
        else $error("scaled width is zero");

    a_height_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[31:16] != 16'd0)
        else $error("scaled height is zero");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while result slot is empty");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[39:33] == 7'd0)
        else $error("result pad bits not zero");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result dropped or changed while stalled");

endmodule

bind image_scaled_size_and_filter isf_checker u_isf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
